### hw/rtl/mnr_pkg.sv
// Shared types, field widths and message codes for the MIDI note remapper.
// No dependencies; every other file of the block but mnr_ram imports this package.
`default_nettype none

package mnr_pkg;

	// Field widths
	localparam int KEY_W        = 7;
	localparam int STATUS_W     = 8;
	localparam int SCENE_FLD_W  = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 1;
	localparam int NUM_KEYS     = 1 << KEY_W;

	// Item kinds
	localparam logic CMD_MIDI      = 1'b0;
	localparam logic CMD_MAP_WRITE = 1'b1;

	// MIDI message types (high nibble of the status byte)
	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
	localparam logic [3:0] TYPE_PROGRAM  = 4'hC;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_SCENE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_PROGRAM = 1'b1;

	// One accepted input item
	typedef struct packed {
		logic                   cmd;
		logic [STATUS_W-1:0]    status_byte;
		logic [KEY_W-1:0]       data_one;
		logic [KEY_W-1:0]       data_two;
		logic [SCENE_FLD_W-1:0] map_scene;
		logic [KEY_W-1:0]       map_source;
		logic                   map_enable;
		logic [KEY_W-1:0]       map_target;
	} mnr_item_t;

	// Decisions the remap logic hands back to the pipeline
	typedef struct packed {
		logic emit;      // item produces a result
		logic map_we;    // table write to a valid scene
		logic held_we;   // release stack changed
		logic scene_we;  // program change switches the scene
	} mnr_ctl_t;

	// Channels above the tracked range share the last tracked channel
	function automatic logic [3:0] sat_channel(input logic [3:0] ch, input int unsigned num);
		logic [3:0] res;
		if (int'(ch) >= num)
			res = 4'(num - 1);
		else
			res = ch;
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mnr_if.sv
// Valid/ready channel interfaces for the MIDI note remapper: input items and results.
// Depends on mnr_pkg for field widths.
`default_nettype none

interface mnr_in_if import mnr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [STATUS_W-1:0]    status_byte;
	logic [KEY_W-1:0]       data_one;
	logic [KEY_W-1:0]       data_two;
	logic [SCENE_FLD_W-1:0] map_scene;
	logic [KEY_W-1:0]       map_source;
	logic                   map_enable;
	logic [KEY_W-1:0]       map_target;

	modport source (
		output valid, cmd, status_byte, data_one, data_two,
		output map_scene, map_source, map_enable, map_target,
		input  ready
	);
	modport sink (
		input  valid, cmd, status_byte, data_one, data_two,
		input  map_scene, map_source, map_enable, map_target,
		output ready
	);
endinterface

interface mnr_out_if import mnr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] out_status;
	logic [KEY_W-1:0]    out_data_one;
	logic [KEY_W-1:0]    out_data_two;

	modport source (
		output valid, out_status, out_data_one, out_data_two,
		input  ready
	);
	modport sink (
		input  valid, out_status, out_data_one, out_data_two,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/midi_note_remap_with_release_tracking.sv
// Top level of the MIDI note remapper with release tracking: s1 stage, table and
// stack RAMs, clear sweep, result register. Depends on mnr_pkg, mnr_if, mnr_ram, mnr_remap_core.
//
//   channel   dir   handshake          transaction
//   item      in    valid/ready        MIDI message or one table-entry write
//   result    out   valid/ready        forwarded MIDI message (0 or 1 per item)
//   cfg       in    cfg_we             register write, cfg_index / cfg_data
//
// One item per cycle sustained while the result side takes results; an accepted item is
// read from the RAMs into s1, then remapped into the result register.
// Table and stack read-modify-write uses a one-deep bypass from s1 to the next item.
// After reset a clear sweep writes every address of both RAMs, with item.ready low. A
// stalled result holds s1; one more item waits in s1 while the result register is full.
`default_nettype none

module midi_note_remap_with_release_tracking import mnr_pkg::*; #(
	parameter int NUM_SCENES   = 8,
	parameter int STACK_DEPTH  = 4,
	parameter int NUM_CHANNELS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	mnr_in_if.sink                     item,
	mnr_out_if.source                  result
);

	localparam int SW         = (NUM_SCENES > 1) ? $clog2(NUM_SCENES) : 1;
	localparam int CW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MAW        = SW + KEY_W;
	localparam int HAW        = CW + KEY_W;
	localparam int MAP_DEPTH  = 1 << MAW;
	localparam int HELD_DEPTH = 1 << HAW;
	localparam int CNTW       = $clog2(STACK_DEPTH + 1);
	localparam int HEW        = CNTW + KEY_W * STACK_DEPTH;
	localparam int CLR_LEN    = (MAP_DEPTH > HELD_DEPTH) ? MAP_DEPTH : HELD_DEPTH;
	localparam int CLRW       = $clog2(CLR_LEN);

	// Configuration and scene
	logic            cfg_switch_q;
	logic            cfg_drop_q;
	logic [SW-1:0]   scene_q;

	// Clear sweep
	logic            clr_busy_q;
	logic [CLRW-1:0] clr_cnt_q;

	// s1 stage
	logic            valid_s1;
	mnr_item_t       item_s1;
	logic            map_fwd_s1;
	logic [KEY_W:0]  map_fwd_data_s1;
	logic            held_fwd_s1;
	logic [HEW-1:0]  held_fwd_data_s1;

	// Result register
	logic             out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [KEY_W-1:0] out_data_one_q;
	logic [KEY_W-1:0] out_data_two_q;

	// Datapath
	mnr_item_t        item_in;
	logic             in_fire;
	logic             s1_fire;
	mnr_ctl_t         ctl;
	logic [KEY_W-1:0] key_out;
	logic [HEW-1:0]   held_next;
	logic [SW-1:0]    scene_next;
	logic [SW-1:0]    scene_rd;
	logic [3:0]       ch_rd;
	logic [3:0]       ch_wr;
	logic [7:0]       map_scene_ext;
	logic [MAW-1:0]   map_raddr;
	logic [MAW-1:0]   map_waddr_item;
	logic [KEY_W:0]   map_wdata_item;
	logic [HAW-1:0]   held_raddr;
	logic [HAW-1:0]   held_waddr_item;
	logic [KEY_W:0]   map_rdata;
	logic [HEW-1:0]   held_rdata;
	logic [KEY_W:0]   map_entry;
	logic [HEW-1:0]   held_entry;
	logic             map_we;
	logic [MAW-1:0]   map_waddr;
	logic [KEY_W:0]   map_wdata;
	logic             held_we;
	logic [HAW-1:0]   held_waddr;
	logic [HEW-1:0]   held_wdata;

	// Handshakes
	assign s1_fire    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !clr_busy_q && (!valid_s1 || s1_fire);
	assign in_fire    = item.valid && item.ready;

	assign item_in.cmd         = item.cmd;
	assign item_in.status_byte = item.status_byte;
	assign item_in.data_one    = item.data_one;
	assign item_in.data_two    = item.data_two;
	assign item_in.map_scene   = item.map_scene;
	assign item_in.map_source  = item.map_source;
	assign item_in.map_enable  = item.map_enable;
	assign item_in.map_target  = item.map_target;

	// Read addresses for the incoming item; scene follows a switch in s1
	always_comb begin
		scene_rd   = (s1_fire && ctl.scene_we) ? scene_next : scene_q;
		ch_rd      = sat_channel(item.status_byte[3:0], NUM_CHANNELS);
		map_raddr  = {scene_rd, item.data_one};
		held_raddr = {ch_rd[CW-1:0], item.data_one};
	end

	// Write addresses of the item in s1
	always_comb begin
		map_scene_ext   = {5'b0, item_s1.map_scene};
		ch_wr           = sat_channel(item_s1.status_byte[3:0], NUM_CHANNELS);
		map_waddr_item  = {map_scene_ext[SW-1:0], item_s1.map_source};
		map_wdata_item  = {item_s1.map_enable, item_s1.map_target};
		held_waddr_item = {ch_wr[CW-1:0], item_s1.data_one};
	end

	// RAM write ports: clear sweep first, then item writes
	always_comb begin
		if (clr_busy_q) begin
			map_we     = ({1'b0, clr_cnt_q} < (CLRW+1)'(MAP_DEPTH));
			map_waddr  = clr_cnt_q[MAW-1:0];
			map_wdata  = '0;
			held_we    = ({1'b0, clr_cnt_q} < (CLRW+1)'(HELD_DEPTH));
			held_waddr = clr_cnt_q[HAW-1:0];
			held_wdata = '0;
		end else begin
			map_we     = s1_fire && ctl.map_we;
			map_waddr  = map_waddr_item;
			map_wdata  = map_wdata_item;
			held_we    = s1_fire && ctl.held_we;
			held_waddr = held_waddr_item;
			held_wdata = held_next;
		end
	end

	mnr_ram #(
		.WIDTH (KEY_W + 1),
		.DEPTH (MAP_DEPTH)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (in_fire),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	mnr_ram #(
		.WIDTH (HEW),
		.DEPTH (HELD_DEPTH)
	) u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (held_waddr),
		.wdata (held_wdata),
		.re    (in_fire),
		.raddr (held_raddr),
		.rdata (held_rdata)
	);

	// Bypassed RAM data for s1
	assign map_entry  = map_fwd_s1 ? map_fwd_data_s1 : map_rdata;
	assign held_entry = held_fwd_s1 ? held_fwd_data_s1 : held_rdata;

	mnr_remap_core #(
		.NUM_SCENES  (NUM_SCENES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_core (
		.item       (item_s1),
		.map_entry  (map_entry),
		.held_entry (held_entry),
		.cfg_switch (cfg_switch_q),
		.cfg_drop   (cfg_drop_q),
		.ctl        (ctl),
		.key_out    (key_out),
		.held_next  (held_next),
		.scene_next (scene_next)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_switch_q <= 1'b0;
			cfg_drop_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SWITCH_SCENE: cfg_switch_q <= cfg_data[0];
				CFG_DROP_PROGRAM: cfg_drop_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Active scene
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scene_q <= '0;
		else if (s1_fire && ctl.scene_we)
			scene_q <= scene_next;
	end

	// Clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLRW'(CLR_LEN - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (s1_fire)
			valid_s1 <= 1'b0;
	end

	// s1 payload and bypass from the item leaving s1
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1          <= item_in;
			map_fwd_s1       <= s1_fire && ctl.map_we && (map_waddr_item == map_raddr);
			map_fwd_data_s1  <= map_wdata_item;
			held_fwd_s1      <= s1_fire && ctl.held_we && (held_waddr_item == held_raddr);
			held_fwd_data_s1 <= held_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_fire && ctl.emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctl.emit) begin
			out_status_q   <= item_s1.status_byte;
			out_data_one_q <= key_out;
			out_data_two_q <= item_s1.data_two;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_status   = out_status_q;
	assign result.out_data_one = out_data_one_q;
	assign result.out_data_two = out_data_two_q;

endmodule

`default_nettype wire

### hw/rtl/mnr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module mnr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/mnr_remap_core.sv
// Per-item remap logic: key substitution, release stack push/pop, scene switch.
// Depends on mnr_pkg; purely combinational, sits between the s1 stage and the result register.
`default_nettype none

module mnr_remap_core import mnr_pkg::*; #(
	parameter int NUM_SCENES  = 8,
	parameter int STACK_DEPTH = 4,
	localparam int SW   = (NUM_SCENES > 1) ? $clog2(NUM_SCENES) : 1,
	localparam int CNTW = $clog2(STACK_DEPTH + 1),
	localparam int HEW  = CNTW + KEY_W * STACK_DEPTH
) (
	input  wire mnr_item_t      item,
	input  wire logic [KEY_W:0] map_entry,   // {enable, target}
	input  wire logic [HEW-1:0] held_entry,  // {targets, count}
	input  wire logic           cfg_switch,
	input  wire logic           cfg_drop,
	output mnr_ctl_t           ctl,
	output logic [KEY_W-1:0]   key_out,
	output logic [HEW-1:0]     held_next,
	output logic [SW-1:0]      scene_next
);

	logic [3:0]       msg_type;
	logic             is_midi;
	logic             is_note;
	logic             note_on;
	logic             prog_switch;
	logic [7:0]       d1_ext;
	logic [7:0]       scene_ext;
	logic             map_en;
	logic [KEY_W-1:0] map_tgt;
	logic [CNTW-1:0]  count;
	logic [CNTW-1:0]  count_next;
	logic             stack_full;
	logic [KEY_W-1:0] slot      [STACK_DEPTH];
	logic [KEY_W-1:0] slot_next [STACK_DEPTH];
	logic [KEY_W-1:0] popped;

	// Message decode
	always_comb begin
		msg_type    = item.status_byte[7:4];
		is_midi     = (item.cmd == CMD_MIDI);
		d1_ext      = {1'b0, item.data_one};
		scene_ext   = {5'b0, item.map_scene};
		prog_switch = is_midi && (msg_type == TYPE_PROGRAM) && cfg_switch
			&& (d1_ext < 8'(NUM_SCENES));
		is_note     = is_midi && ((msg_type == TYPE_NOTE_OFF) || (msg_type == TYPE_NOTE_ON));
		note_on     = (msg_type == TYPE_NOTE_ON) && (item.data_two != '0);
		map_en      = map_entry[KEY_W];
		map_tgt     = map_entry[KEY_W-1:0];
		scene_next  = d1_ext[SW-1:0];
	end

	// Release stack: unpack, push on note-on, pop on release
	always_comb begin
		count = held_entry[CNTW-1:0];
		for (int i = 0; i < STACK_DEPTH; i++)
			slot[i] = held_entry[CNTW + KEY_W*i +: KEY_W];
		stack_full = (count == CNTW'(STACK_DEPTH));

		// top of stack for a pop
		popped = '0;
		for (int i = 0; i < STACK_DEPTH; i++)
			if (CNTW'(i + 1) == count)
				popped = slot[i];

		for (int i = 0; i < STACK_DEPTH; i++)
			slot_next[i] = slot[i];
		count_next = count;

		if (note_on) begin
			if (stack_full) begin
				// oldest entry drops out at the bottom
				for (int i = 0; i < STACK_DEPTH - 1; i++)
					slot_next[i] = slot[i + 1];
				slot_next[STACK_DEPTH-1] = map_tgt;
			end else begin
				for (int i = 0; i < STACK_DEPTH; i++)
					if (CNTW'(i) == count)
						slot_next[i] = map_tgt;
				count_next = count + 1'b1;
			end
		end else if (count != '0) begin
			count_next = count - 1'b1;
		end

		held_next[CNTW-1:0] = count_next;
		for (int i = 0; i < STACK_DEPTH; i++)
			held_next[CNTW + KEY_W*i +: KEY_W] = slot_next[i];
	end

	// Output key and write decisions
	always_comb begin
		key_out = item.data_one;
		if (is_note) begin
			if (note_on) begin
				if (map_en)
					key_out = map_tgt;
			end else if (count != '0) begin
				key_out = popped;
			end else if (map_en) begin
				key_out = map_tgt;
			end
		end

		ctl.emit     = is_midi && !(prog_switch && cfg_drop);
		ctl.map_we   = (item.cmd == CMD_MAP_WRITE) && (scene_ext < 8'(NUM_SCENES));
		ctl.held_we  = is_note && (note_on ? map_en : (count != '0));
		ctl.scene_we = prog_switch;
	end

endmodule

`default_nettype wire

### hw/rtl/mnr_checker.sv
// Port-level checks for the MIDI note remapper, bound to the top level.
// Depends on mnr_pkg and midi_note_remap_with_release_tracking.
`default_nettype none

module mnr_checker import mnr_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire logic                item_cmd,
	input wire logic [STATUS_W-1:0] item_status,
	input wire logic [KEY_W-1:0]    item_data_two,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire logic [STATUS_W-1:0] result_status,
	input wire logic [KEY_W-1:0]    result_data_one,
	input wire logic [KEY_W-1:0]    result_data_two
);

	// A pending result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A pending result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_status)
			&& $stable(result_data_one) && $stable(result_data_two))
		else $error("result payload changed while stalled");

	// A fresh result comes from an accepted MIDI message
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && (item_cmd == CMD_MIDI), 2))
		else $error("result without a matching MIDI transaction");

	// Status and second data byte pass through untouched
	a_result_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> (result_status == $past(item_status, 2))
			&& (result_data_two == $past(item_data_two, 2)))
		else $error("status or second data byte altered");

endmodule

bind midi_note_remap_with_release_tracking mnr_checker u_mnr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_cmd        (item.cmd),
	.item_status     (item.status_byte),
	.item_data_two   (item.data_two),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_status   (result.out_status),
	.result_data_one (result.out_data_one),
	.result_data_two (result.out_data_two)
);

`default_nettype wire

### bench/midi_note_remap_with_release_tracking_tb.sv
// Self-checking bench for the MIDI note remapper: a directed table, then random phases.
// Each phase uses its own register setting; a scoreboard predicts and checks every result.
// Depends on mnr_pkg, mnr_if and the midi_note_remap_with_release_tracking top level.
`timescale 1ns / 100ps

module midi_note_remap_with_release_tracking_tb;
	import mnr_pkg::*;

	localparam int TB_SCENES       = 8;
	localparam int TB_DEPTH        = 4;
	localparam int TB_CHANNELS     = 16;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 195;
	localparam int SETTLE_CYCLES   = 6;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 10000;

	// Keys and channels that random traffic favors so that stacks fill and drain
	localparam logic [KEY_W-1:0] HOT_KEYS [6] = '{7'd0, 7'd36, 7'd60, 7'd64, 7'd100, 7'd127};
	localparam logic [3:0]       HOT_CHANS [3] = '{4'd0, 4'd9, 4'd15};

	// One forwarded MIDI message
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key;
		logic [KEY_W-1:0]    data_two;
	} note_msg_t;

	// One row of the directed table: a register write or an item
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic                 reg_val;
		mnr_item_t            it;
		bit                   typed;
		bit                   emits;
		note_msg_t            msg;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mnr_in_if  in_bus ();
	mnr_out_if out_bus ();

	midi_note_remap_with_release_tracking #(
		.NUM_SCENES   (TB_SCENES),
		.STACK_DEPTH  (TB_DEPTH),
		.NUM_CHANNELS (TB_CHANNELS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (in_bus),
		.result    (out_bus)
	);

	// Shadow copy of the block state
	bit                   sw_on_prog;
	bit                   drop_prog;
	bit [SCENE_FLD_W-1:0] cur_scene;
	bit                   tbl_en   [TB_SCENES][NUM_KEYS];
	bit [KEY_W-1:0]       tbl_tgt  [TB_SCENES][NUM_KEYS];
	int unsigned          held_n   [TB_CHANNELS][NUM_KEYS];
	bit [KEY_W-1:0]       held_keys[TB_CHANNELS][NUM_KEYS][TB_DEPTH];

	note_msg_t pending_msgs[$];
	dir_row_t  dir_rows[$];

	bit gaps_on  = 1'b1;
	bit hold_req = 1'b0;
	int n_errors;
	int n_items;
	int n_directed;
	int n_results;
	int n_tbl_writes;
	int n_switches;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Remap prediction; returns 1 when the item forwards a message
	function automatic bit remap_note(input mnr_item_t it, output note_msg_t msg);
		logic [3:0]       kind;
		logic [3:0]       ch;
		bit               en;
		bit [KEY_W-1:0]   tgt;
		int unsigned      d;
		msg = '{it.status_byte, it.data_one, it.data_two};
		kind = it.status_byte[7:4];
		// table write: no result
		if (it.cmd == CMD_MAP_WRITE) begin
			if (it.map_scene < TB_SCENES) begin
				tbl_en[it.map_scene][it.map_source] = it.map_enable;
				tbl_tgt[it.map_scene][it.map_source] = it.map_target;
				n_tbl_writes++;
			end
			return 1'b0;
		end
		if (kind == TYPE_PROGRAM && sw_on_prog && it.data_one < TB_SCENES) begin
			cur_scene = it.data_one[SCENE_FLD_W-1:0];
			n_switches++;
			if (drop_prog)
				return 1'b0;
		end else if (kind == TYPE_NOTE_OFF || kind == TYPE_NOTE_ON) begin
			ch = it.status_byte[3:0];
			if (ch > TB_CHANNELS - 1)
				ch = 4'(TB_CHANNELS - 1);
			en = tbl_en[cur_scene][it.data_one];
			tgt = tbl_tgt[cur_scene][it.data_one];
			if (kind == TYPE_NOTE_ON && it.data_two != 0) begin
				// press: remap and remember the target, shifting out the oldest when full
				if (en) begin
					msg.key = tgt;
					d = held_n[ch][it.data_one];
					if (d < TB_DEPTH) begin
						held_keys[ch][it.data_one][d] = tgt;
						held_n[ch][it.data_one] = d + 1;
					end else begin
						for (int i = 1; i < TB_DEPTH; i++)
							held_keys[ch][it.data_one][i-1] = held_keys[ch][it.data_one][i];
						held_keys[ch][it.data_one][TB_DEPTH-1] = tgt;
					end
				end
			end else begin
				// release: newest held target, else the table, else the key itself
				d = held_n[ch][it.data_one];
				if (d != 0) begin
					held_n[ch][it.data_one] = d - 1;
					msg.key = held_keys[ch][it.data_one][d-1];
				end else if (en) begin
					msg.key = tgt;
				end
			end
		end
		return 1'b1;
	endfunction

	// Directed table builders
	function automatic void add_note(input logic [7:0] st, input logic [6:0] d1,
			input logic [6:0] d2);
		dir_row_t r;
		r = '{default: '0};
		r.it.cmd = CMD_MIDI;
		r.it.status_byte = st;
		r.it.data_one = d1;
		r.it.data_two = d2;
		dir_rows.push_back(r);
	endfunction

	// Rows whose message leaves untouched (or not at all)
	function automatic void add_fixed(input logic [7:0] st, input logic [6:0] d1,
			input logic [6:0] d2, input bit emits);
		dir_row_t r;
		r = '{default: '0};
		r.it.cmd = CMD_MIDI;
		r.it.status_byte = st;
		r.it.data_one = d1;
		r.it.data_two = d2;
		r.typed = 1'b1;
		r.emits = emits;
		r.msg = '{st, d1, d2};
		dir_rows.push_back(r);
	endfunction

	function automatic void add_map(input logic [2:0] sc, input logic [6:0] src,
			input logic en, input logic [6:0] tgt, input logic [7:0] st);
		dir_row_t r;
		r = '{default: '0};
		r.it.cmd = CMD_MAP_WRITE;
		r.it.status_byte = st;
		r.it.map_scene = sc;
		r.it.map_source = src;
		r.it.map_enable = en;
		r.it.map_target = tgt;
		r.typed = 1'b1;
		r.emits = 1'b0;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		dir_rows.push_back(r);
	endfunction

	// Random item, biased toward note traffic on a few keys and channels
	function automatic mnr_item_t rand_item();
		mnr_item_t        it;
		int unsigned      pick;
		logic [KEY_W-1:0] key;
		logic [3:0]       chan;
		it.cmd = CMD_MIDI;
		it.status_byte = 8'($urandom_range(255));
		it.data_one = 7'($urandom_range(127));
		it.data_two = 7'($urandom_range(127));
		it.map_scene = 3'($urandom_range(7));
		it.map_source = 7'($urandom_range(127));
		it.map_enable = 1'($urandom_range(1));
		it.map_target = 7'($urandom_range(127));
		key = ($urandom_range(99) < 75) ? HOT_KEYS[$urandom_range(5)] : 7'($urandom_range(127));
		chan = ($urandom_range(99) < 60) ? HOT_CHANS[$urandom_range(2)] : 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 14) begin
			it.cmd = CMD_MAP_WRITE;
			it.map_source = key;
			if ($urandom_range(99) < 70)
				it.map_scene = 3'($urandom_range(2));
		end else if (pick < 48) begin
			it.status_byte = {TYPE_NOTE_ON, chan};
			it.data_one = key;
			it.data_two = ($urandom_range(99) < 12) ? 7'd0 : 7'($urandom_range(127, 1));
		end else if (pick < 80) begin
			it.data_one = key;
			if ($urandom_range(1)) begin
				it.status_byte = {TYPE_NOTE_OFF, chan};
			end else begin
				it.status_byte = {TYPE_NOTE_ON, chan};
				it.data_two = 7'd0;
			end
		end else if (pick < 88) begin
			it.status_byte = {TYPE_PROGRAM, 4'($urandom_range(15))};
			if ($urandom_range(99) < 80)
				it.data_one = 7'($urandom_range(9));
		end
		return it;
	endfunction

	// Offer one item; on acceptance, record what it should produce
	task automatic send_item(input mnr_item_t it, input bit typed, input bit emits,
			input note_msg_t typed_msg);
		note_msg_t msg;
		bit        has_msg;
		while (gaps_on && $urandom_range(99) < 20) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid       <= 1'b1;
		in_bus.cmd         <= it.cmd;
		in_bus.status_byte <= it.status_byte;
		in_bus.data_one    <= it.data_one;
		in_bus.data_two    <= it.data_two;
		in_bus.map_scene   <= it.map_scene;
		in_bus.map_source  <= it.map_source;
		in_bus.map_enable  <= it.map_enable;
		in_bus.map_target  <= it.map_target;
		@(posedge clk);
		while (in_bus.ready !== 1'b1)
			@(posedge clk);
		has_msg = remap_note(it, msg);
		if (typed) begin
			has_msg = emits;
			msg = typed_msg;
		end
		if (has_msg)
			pending_msgs.push_back(msg);
		n_items++;
	endtask

	// Register write while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CFG_SWITCH_SCENE)
			sw_on_prog = val;
		else
			drop_prog = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for all outstanding messages plus the pipeline latency
	task automatic settle();
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random back-pressure plus one long hold-off on request
	initial begin
		out_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(99) < 20) begin
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// Scoreboard: compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		note_msg_t want;
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			if (pending_msgs.size() == 0) begin
				$error("unexpected result: status %h key %0d data_two %0d",
					out_bus.out_status, out_bus.out_data_one, out_bus.out_data_two);
				n_errors++;
			end else begin
				want = pending_msgs.pop_front();
				n_results++;
				if (out_bus.out_status !== want.status) begin
					$error("out_status: expected %h, got %h", want.status, out_bus.out_status);
					n_errors++;
				end
				if (out_bus.out_data_one !== want.key) begin
					$error("out_data_one: expected %0d, got %0d", want.key, out_bus.out_data_one);
					n_errors++;
				end
				if (out_bus.out_data_two !== want.data_two) begin
					$error("out_data_two: expected %0d, got %0d", want.data_two,
						out_bus.out_data_two);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
					(out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Main sequence
	initial begin
		bit sw_val;
		bit drop_val;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_bus.valid       = 1'b0;
		in_bus.cmd         = CMD_MIDI;
		in_bus.status_byte = '0;
		in_bus.data_one    = '0;
		in_bus.data_two    = '0;
		in_bus.map_scene   = '0;
		in_bus.map_source  = '0;
		in_bus.map_enable  = 1'b0;
		in_bus.map_target  = '0;

		// unmapped key after reset passes through
		add_fixed({TYPE_NOTE_ON, 4'h0}, 7'd60, 7'd100, 1'b1);
		// press and release across two channels with a table change in between
		add_map(3'd0, 7'd60, 1'b1, 7'd72, 8'h00);
		add_note({TYPE_NOTE_ON, 4'h0}, 7'd60, 7'd127);
		add_map(3'd0, 7'd60, 1'b1, 7'd48, 8'hFF);
		add_note({TYPE_NOTE_ON, 4'hF}, 7'd60, 7'd1);
		add_note({TYPE_NOTE_OFF, 4'h0}, 7'd60, 7'd0);
		add_note({TYPE_NOTE_ON, 4'hF}, 7'd60, 7'd0);
		// full stack: oldest target falls out, empty stack falls back to the table
		add_map(3'd0, 7'd127, 1'b1, 7'd0, 8'h00);
		add_note({TYPE_NOTE_ON, 4'h3}, 7'd127, 7'd100);
		add_map(3'd0, 7'd127, 1'b1, 7'd127, 8'h00);
		repeat (4) add_note({TYPE_NOTE_ON, 4'h3}, 7'd127, 7'd127);
		repeat (5) add_note({TYPE_NOTE_OFF, 4'h3}, 7'd127, 7'd0);
		// data bytes in the status slot and system messages pass through
		add_fixed(8'h00, 7'd0, 7'd0, 1'b1);
		add_fixed(8'hFF, 7'd127, 7'd127, 1'b1);
		// program change: switch and forward, out-of-range program, switch and drop
		add_reg(CFG_SWITCH_SCENE, 1'b1);
		add_fixed({TYPE_PROGRAM, 4'h0}, 7'd1, 7'd0, 1'b1);
		add_note({TYPE_NOTE_ON, 4'h0}, 7'd60, 7'd5);
		add_fixed({TYPE_PROGRAM, 4'h5}, 7'd8, 7'd3, 1'b1);
		add_reg(CFG_DROP_PROGRAM, 1'b1);
		add_fixed({TYPE_PROGRAM, 4'hF}, 7'd0, 7'd127, 1'b0);
		add_map(3'd7, 7'd127, 1'b1, 7'd127, 8'h00);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				in_bus.valid <= 1'b0;
				settle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].emits,
					dir_rows[i].msg);
			end
		end
		n_directed = n_items;

		// random phases, each under its own register setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			in_bus.valid <= 1'b0;
			settle();
			case (phase)
				0: begin sw_val = 1'b1; drop_val = 1'b1; end
				1: begin sw_val = 1'b0; drop_val = 1'b1; end
				2: begin sw_val = 1'b1; drop_val = 1'b0; end
				3: begin sw_val = 1'b0; drop_val = 1'b0; end
				default: begin
					sw_val = 1'($urandom_range(1));
					drop_val = 1'($urandom_range(1));
				end
			endcase
			write_reg(CFG_SWITCH_SCENE, sw_val);
			write_reg(CFG_DROP_PROGRAM, drop_val);
			// one phase without any idling, one with a long result stall
			gaps_on = (phase != 3);
			if (phase == 1)
				hold_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(rand_item(), 1'b0, 1'b0, '0);
		end
		in_bus.valid <= 1'b0;
		settle();

		$display("covered %0d items (%0d directed), %0d results checked, %0d table writes, %0d scene switches",
			n_items, n_directed, n_results, n_tbl_writes, n_switches);
		$display("register settings incl. all four combinations, random stalls, one %0d-cycle hold",
			HOLD_CYCLES);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### midi_note_remap_with_release_tracking.f
hw/rtl/mnr_pkg.sv
hw/rtl/mnr_if.sv
hw/rtl/mnr_ram.sv
hw/rtl/mnr_remap_core.sv
hw/rtl/midi_note_remap_with_release_tracking.sv
hw/rtl/mnr_checker.sv
bench/midi_note_remap_with_release_tracking_tb.sv
